[rtl/gwm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Glob wildcard matcher package
// Shared types and constants for the glob matcher: item formats, the opcode
// values, the internal command format and the default sizes.
// ----------------------------------------------------------------------------
package gwm_pkg;

  localparam int PATTERN_MAX_DEF = 32;
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic [7:0] STAR_BYTE  = 8'd42;
  localparam logic [7:0] QUERY_BYTE = 8'd63;

  localparam logic [1:0] OP_CLEAR   = 2'd0;
  localparam logic [1:0] OP_APPEND  = 2'd1;
  localparam logic [1:0] OP_SUBJECT = 2'd2;
  localparam logic [1:0] OP_REPORT  = 2'd3;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] char_byte;
  } in_item_t;

  typedef struct packed {
    logic matched;
    logic overflow;
  } out_item_t;

  typedef enum logic [1:0] {
    CMD_CLEAR,
    CMD_APPEND,
    CMD_SUBJECT,
    CMD_REPORT
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] char_byte;
    logic       is_star;
    logic       is_query;
  } cmd_t;

endpackage

[rtl/gwm_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Glob matcher front end
// Takes input transfers into a register stage, decodes the opcode and marks
// wildcard bytes before the command is handed to the queue.
// ----------------------------------------------------------------------------
module gwm_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  gwm_pkg::in_item_t in_item,
  output logic             cmd_valid,
  input  logic             cmd_ready,
  output gwm_pkg::cmd_t    cmd
);
  import gwm_pkg::*;

  logic      front_v_r;
  logic      front_v_nxt;
  cmd_t      front_cmd_r;
  cmd_t      front_cmd_nxt;
  cmd_kind_t kind_dec;

  always_comb begin
    unique case (in_item.opcode)
      OP_CLEAR:   kind_dec = CMD_CLEAR;
      OP_APPEND:  kind_dec = CMD_APPEND;
      OP_SUBJECT: kind_dec = CMD_SUBJECT;
      default:    kind_dec = CMD_REPORT;
    endcase
  end

  assign in_ready  = !front_v_r || cmd_ready;
  assign cmd_valid = front_v_r;
  assign cmd       = front_cmd_r;

  always_comb begin
    front_v_nxt   = front_v_r;
    front_cmd_nxt = front_cmd_r;
    if (in_valid && in_ready) begin
      front_v_nxt             = 1'b1;
      front_cmd_nxt.kind      = kind_dec;
      front_cmd_nxt.char_byte = in_item.char_byte;
      front_cmd_nxt.is_star   = (in_item.char_byte == STAR_BYTE);
      front_cmd_nxt.is_query  = (in_item.char_byte == QUERY_BYTE);
    end else if (cmd_ready) begin
      front_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_v_r <= 1'b0;
    end else begin
      front_v_r <= front_v_nxt;
    end
    front_cmd_r <= front_cmd_nxt;
  end

endmodule

[rtl/gwm_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Glob matcher command queue
// A short first-in first-out buffer that decouples the front end from the
// matching engine.
// ----------------------------------------------------------------------------
module gwm_queue #(
  parameter int DEPTH = gwm_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  output logic          push_ready,
  input  gwm_pkg::cmd_t push_cmd,
  output logic          pop_valid,
  input  logic          pop_ready,
  output gwm_pkg::cmd_t pop_cmd
);
  import gwm_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  cmd_t          mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r;
  logic [PW-1:0] wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r;
  logic [PW-1:0] rd_ptr_nxt;
  logic [CW-1:0] count_r;
  logic [CW-1:0] count_nxt;
  logic          do_push;
  logic          do_pop;

  assign push_ready = (count_r != FULL_CNT);
  assign pop_valid  = (count_r != '0);
  assign pop_cmd    = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

[rtl/gwm_engine.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Glob matcher engine
// Holds the pattern and the set of active pattern positions, advances the
// whole set in parallel for each subject byte and registers the report.
// ----------------------------------------------------------------------------
module gwm_engine #(
  parameter int PATTERN_MAX = gwm_pkg::PATTERN_MAX_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cmd_valid,
  output logic               cmd_ready,
  input  gwm_pkg::cmd_t      cmd,
  output logic               out_valid,
  input  logic               out_ready,
  output gwm_pkg::out_item_t out_item
);
  import gwm_pkg::*;

  localparam int AW = PATTERN_MAX + 1;

  // Star closure as a carry chain: stars propagate, active stars generate.
  function automatic logic [AW-1:0] close_stars(input logic [AW-1:0] act,
                                                input logic [PATTERN_MAX-1:0] stars);
    logic [AW-1:0] s;
    logic [AW-1:0] g;
    logic [AW:0]   sum;
    logic [AW:0]   carry;
    s     = {1'b0, stars};
    g     = act & s;
    sum   = {1'b0, g} + {1'b0, s};
    carry = sum ^ {1'b0, g} ^ {1'b0, s};
    return act | carry[AW-1:0];
  endfunction

  logic [7:0]             store_r [PATTERN_MAX];
  logic [PATTERN_MAX-1:0] star_r;
  logic [PATTERN_MAX-1:0] star_nxt;
  logic [PATTERN_MAX-1:0] query_r;
  logic [PATTERN_MAX-1:0] query_nxt;
  logic [PATTERN_MAX-1:0] used_r;
  logic [PATTERN_MAX-1:0] used_nxt;
  logic [AW-1:0]          end_r;
  logic [AW-1:0]          end_nxt;
  logic [AW-1:0]          act_r;
  logic [AW-1:0]          act_nxt;
  logic                   ovf_r;
  logic                   ovf_nxt;
  logic                   out_v_r;
  logic                   out_v_nxt;
  out_item_t              out_item_r;
  out_item_t              out_item_nxt;
  logic                   do_cmd;
  logic                   full;
  logic [PATTERN_MAX-1:0] stay;
  logic [PATTERN_MAX-1:0] hit;
  logic [AW-1:0]          first_pos;

  assign full      = end_r[PATTERN_MAX];
  assign first_pos = AW'(1);
  assign cmd_ready = (cmd.kind != CMD_REPORT) || !out_v_r || out_ready;
  assign do_cmd    = cmd_valid && cmd_ready;
  assign out_valid = out_v_r;
  assign out_item  = out_item_r;

  always_comb begin
    for (int p = 0; p < PATTERN_MAX; p++) begin
      stay[p] = act_r[p] && used_r[p] && star_r[p];
      hit[p]  = act_r[p] && used_r[p] && !star_r[p] &&
                (query_r[p] || (store_r[p] == cmd.char_byte));
    end
  end

  always_comb begin
    star_nxt     = star_r;
    query_nxt    = query_r;
    used_nxt     = used_r;
    end_nxt      = end_r;
    act_nxt      = act_r;
    ovf_nxt      = ovf_r;
    out_v_nxt    = out_v_r && !out_ready;
    out_item_nxt = out_item_r;
    if (do_cmd) begin
      unique case (cmd.kind)
        CMD_CLEAR: begin
          used_nxt = '0;
          end_nxt  = first_pos;
          ovf_nxt  = 1'b0;
          act_nxt  = first_pos;
        end
        CMD_APPEND: begin
          if (!full) begin
            for (int p = 0; p < PATTERN_MAX; p++) begin
              if (end_r[p]) begin
                star_nxt[p]  = cmd.is_star;
                query_nxt[p] = cmd.is_query;
              end
            end
            used_nxt = used_r | end_r[PATTERN_MAX-1:0];
            end_nxt  = {end_r[PATTERN_MAX-1:0], 1'b0};
          end else begin
            ovf_nxt = 1'b1;
          end
          act_nxt = close_stars(first_pos, star_nxt & used_nxt);
        end
        CMD_SUBJECT: begin
          act_nxt = close_stars({1'b0, stay} | {hit, 1'b0}, star_r & used_r);
        end
        CMD_REPORT: begin
          out_v_nxt             = 1'b1;
          out_item_nxt.matched  = !ovf_r && |(act_r & end_r);
          out_item_nxt.overflow = ovf_r;
          act_nxt               = close_stars(first_pos, star_r & used_r);
        end
        default: begin
          act_nxt = act_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r  <= '0;
      end_r   <= first_pos;
      act_r   <= first_pos;
      ovf_r   <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      used_r  <= used_nxt;
      end_r   <= end_nxt;
      act_r   <= act_nxt;
      ovf_r   <= ovf_nxt;
      out_v_r <= out_v_nxt;
    end
    star_r     <= star_nxt;
    query_r    <= query_nxt;
    out_item_r <= out_item_nxt;
    for (int p = 0; p < PATTERN_MAX; p++) begin
      if (do_cmd && (cmd.kind == CMD_APPEND) && end_r[p]) begin
        store_r[p] <= cmd.char_byte;
      end
    end
  end

endmodule

[rtl/glob_wildcard_matcher_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Glob wildcard matcher
// Matches a streamed subject against a loaded glob pattern with star and
// question-mark wildcards, giving one result for each end-of-subject command.
// ----------------------------------------------------------------------------
// Channel   Direction  Payload                          Handshake
// in_       input      in_item_t  (opcode, char_byte)   in_valid / in_ready
// out_      output     out_item_t (matched, overflow)   out_valid / out_ready
//
// One input transfer is taken every cycle while in_ready is high; the engine
// updates all pattern positions for a subject byte in parallel.
// A report passes through the front register, the queue and the engine's
// output register on its way to out_.
// Reset is synchronous and needs no clearing pass; pattern bytes are
// undefined until written.
// A stalled output holds the next report at the head of the queue; QUEUE_DEPTH - 1
// more commands can wait in the queue and one in the front register before in_ready falls.
module glob_wildcard_matcher_core #(
  parameter int PATTERN_MAX = gwm_pkg::PATTERN_MAX_DEF,
  parameter int QUEUE_DEPTH = gwm_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  gwm_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output gwm_pkg::out_item_t out_item
);
  import gwm_pkg::*;

  logic fr_valid;
  logic fr_ready;
  cmd_t fr_cmd;
  logic q_valid;
  logic q_ready;
  cmd_t q_cmd;

  gwm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .cmd_valid (fr_valid),
    .cmd_ready (fr_ready),
    .cmd       (fr_cmd)
  );

  gwm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fr_valid),
    .push_ready (fr_ready),
    .push_cmd   (fr_cmd),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_cmd    (q_cmd)
  );

  gwm_engine #(
    .PATTERN_MAX (PATTERN_MAX)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (q_valid),
    .cmd_ready (q_ready),
    .cmd       (q_cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

[rtl/gwm_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Glob matcher port checker
// Concurrent checks on the top-level ports, attached by a bind statement.
// ----------------------------------------------------------------------------
module gwm_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input gwm_pkg::in_item_t  in_item,
  input logic               out_valid,
  input logic               out_ready,
  input gwm_pkg::out_item_t out_item
);
  import gwm_pkg::*;

  a_ovf_no_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_item.overflow && out_item.matched))
    else $error("report shows a match together with overflow");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("stalled result transfer changed");

  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

  a_reset_ready: assert property (@(posedge clk)
    !rst_n |=> in_ready)
    else $error("input not ready straight after reset");

  a_out_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !$isunknown(out_item))
    else $error("result transfer carries unknown bits");

endmodule

bind glob_wildcard_matcher_core gwm_checker u_gwm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);

[sim/glob_wildcard_matcher_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Glob wildcard matcher testbench
// Loads glob patterns and streams subjects through the matcher. A model of the
// active pattern positions, kept inside this bench, predicts every report.
// Each report is checked against the prediction, field by field. A short
// directed sequence comes first. Random patterns and subjects follow, with
// random idle bursts on both channels.
// ----------------------------------------------------------------------------
module glob_wildcard_matcher_core_tb;
  import gwm_pkg::*;

  localparam int PAT_MAX    = PATTERN_MAX_DEF;
  localparam int RAND_ITEMS = 950;
  localparam int TAIL_ITEMS = 150;
  localparam int IDLE_LIMIT = 1000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;

  glob_wildcard_matcher_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  // Model state of the matcher.
  logic [7:0]       pat_bytes [PAT_MAX];
  int unsigned      pat_len;
  logic             pat_ovf;
  logic [PAT_MAX:0] live_pos;

  out_item_t   due_verdicts [$];
  in_item_t    stim_items [$];
  bit          stim_wait_idle [$];
  bit          hold_next;
  int          rand_count;
  logic [7:0]  gen_pat [$];
  int          feed_idx;
  int          in_gap;
  logic        in_taken;
  int          stall_left;
  int          calm_left;
  int          idle_cycles;
  int          errors;
  int          pattern_count;

  function automatic logic [PAT_MAX:0] star_closure(logic [PAT_MAX:0] act);
    for (int p = 0; p < pat_len && p < PAT_MAX; p++) begin
      if (act[p] && pat_bytes[p] == STAR_BYTE) act[p+1] = 1'b1;
    end
    return act;
  endfunction

  function automatic logic [PAT_MAX:0] restart_set();
    logic [PAT_MAX:0] act;
    act = '0;
    act[0] = 1'b1;
    return star_closure(act);
  endfunction

  task automatic glob_step(input in_item_t it);
    logic [PAT_MAX:0] nxt;
    out_item_t        verdict;
    case (it.opcode)
      OP_CLEAR: begin
        pat_len = 0;
        pat_ovf = 1'b0;
        live_pos = restart_set();
      end
      OP_APPEND: begin
        if (pat_len < PAT_MAX) begin
          pat_bytes[pat_len] = it.char_byte;
          pat_len++;
        end else begin
          pat_ovf = 1'b1;
        end
        live_pos = restart_set();
      end
      OP_SUBJECT: begin
        nxt = '0;
        for (int p = 0; p < pat_len && p < PAT_MAX; p++) begin
          if (live_pos[p]) begin
            if (pat_bytes[p] == STAR_BYTE) nxt[p] = 1'b1;
            else if (pat_bytes[p] == it.char_byte || pat_bytes[p] == QUERY_BYTE)
              nxt[p+1] = 1'b1;
          end
        end
        live_pos = star_closure(nxt);
      end
      default: begin
        verdict.matched = !pat_ovf && live_pos[pat_len];
        verdict.overflow = pat_ovf;
        due_verdicts.push_back(verdict);
        live_pos = restart_set();
      end
    endcase
  endtask

  task automatic push_item(input logic [1:0] op, input logic [7:0] ch);
    in_item_t it;
    it.opcode = op;
    it.char_byte = ch;
    stim_items.push_back(it);
    stim_wait_idle.push_back(hold_next);
    hold_next = 1'b0;
  endtask

  function automatic logic [7:0] subject_sym();
    int r;
    r = $urandom_range(0, 15);
    if (r <= 12) return 8'h61 + 8'(r % 3);
    if (r == 13) return STAR_BYTE;
    if (r == 14) return QUERY_BYTE;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] pattern_sym();
    int r;
    r = $urandom_range(0, 15);
    if (r <= 2) return STAR_BYTE;
    if (r <= 4) return QUERY_BYTE;
    if (r <= 13) return 8'h61 + 8'(r % 3);
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic load_pattern();
    int         len;
    logic [7:0] b;
    if (pattern_count == 0) len = PAT_MAX + 2;
    else if (pattern_count == 1) len = PAT_MAX;
    else if ($urandom_range(0, 9) == 0) len = $urandom_range(PAT_MAX - 2, PAT_MAX + 4);
    else len = $urandom_range(0, 8);
    pattern_count++;
    push_item(OP_CLEAR, 8'($urandom_range(0, 255)));
    gen_pat.delete();
    for (int i = 0; i < len; i++) begin
      b = pattern_sym();
      push_item(OP_APPEND, b);
      if (gen_pat.size() < PAT_MAX) gen_pat.push_back(b);
    end
  endtask

  task automatic stream_subject();
    int         n;
    logic [7:0] b;
    if ($urandom_range(0, 2) != 0) begin
      foreach (gen_pat[i]) begin
        if (gen_pat[i] == STAR_BYTE) begin
          n = $urandom_range(0, 3);
          for (int k = 0; k < n; k++) push_item(OP_SUBJECT, subject_sym());
        end else if (gen_pat[i] == QUERY_BYTE) begin
          push_item(OP_SUBJECT, 8'($urandom_range(0, 255)));
        end else begin
          push_item(OP_SUBJECT, gen_pat[i]);
        end
      end
      if ($urandom_range(0, 3) == 0) push_item(OP_SUBJECT, subject_sym());
    end else begin
      n = $urandom_range(0, 10);
      for (int k = 0; k < n; k++) begin
        if ($urandom_range(0, 14) == 0) begin
          b = pattern_sym();
          push_item(OP_APPEND, b);
          if (gen_pat.size() < PAT_MAX) gen_pat.push_back(b);
        end else begin
          push_item(OP_SUBJECT, subject_sym());
        end
      end
    end
    push_item(OP_REPORT, 8'($urandom_range(0, 255)));
  endtask

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    int base;
    int before_count;
    pat_len = 0;
    pat_ovf = 1'b0;
    live_pos = restart_set();
    hold_next = 1'b0;
    pattern_count = 0;

    push_item(OP_CLEAR, 8'hFF);
    push_item(OP_REPORT, 8'h00);
    push_item(OP_SUBJECT, 8'h00);
    push_item(OP_REPORT, 8'hFF);
    push_item(OP_APPEND, STAR_BYTE);
    push_item(OP_APPEND, STAR_BYTE);
    push_item(OP_REPORT, 8'h00);
    push_item(OP_SUBJECT, STAR_BYTE);
    push_item(OP_SUBJECT, QUERY_BYTE);
    push_item(OP_SUBJECT, 8'hFF);
    push_item(OP_REPORT, 8'h55);
    push_item(OP_CLEAR, 8'h00);
    push_item(OP_APPEND, QUERY_BYTE);
    push_item(OP_APPEND, 8'hFF);
    push_item(OP_APPEND, 8'h00);
    push_item(OP_SUBJECT, 8'h7A);
    push_item(OP_SUBJECT, 8'hFF);
    push_item(OP_SUBJECT, 8'h00);
    push_item(OP_REPORT, 8'hAA);
    push_item(OP_SUBJECT, 8'h7A);
    push_item(OP_APPEND, 8'h61);
    push_item(OP_REPORT, 8'h00);

    // The sender waits for every outstanding report here and halfway through.
    hold_next = 1'b1;
    base = stim_items.size();
    while (stim_items.size() - base < RAND_ITEMS) begin
      before_count = stim_items.size() - base;
      if ($urandom_range(0, 9) == 0) begin
        push_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
      end else begin
        if (pattern_count == 0 || $urandom_range(0, 2) == 0) load_pattern();
        repeat ($urandom_range(1, 4)) stream_subject();
      end
      if (before_count < RAND_ITEMS / 2 && stim_items.size() - base >= RAND_ITEMS / 2)
        hold_next = 1'b1;
    end

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    do @(posedge clk);
    while (feed_idx < stim_items.size() || in_valid || due_verdicts.size() != 0);
    repeat (20) @(posedge clk);
    if (due_verdicts.size() != 0) begin
      $display("%0t: %0d expected reports never arrived", $time, due_verdicts.size());
      errors++;
    end
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Sender: presents items at the falling edge and holds them until transfer.
  always @(negedge clk) begin : drive_proc
    logic     nxt_valid;
    in_item_t nxt_item;
    nxt_valid = in_valid;
    nxt_item = in_item;
    if (rst_n && !(in_valid && !in_taken)) begin
      nxt_valid = 1'b0;
      if (in_gap > 0) begin
        in_gap--;
      end else if (feed_idx < stim_items.size() &&
                   !(stim_wait_idle[feed_idx] && due_verdicts.size() != 0)) begin
        nxt_valid = 1'b1;
        nxt_item = stim_items[feed_idx];
        feed_idx++;
        if (feed_idx + TAIL_ITEMS < stim_items.size() && $urandom_range(0, 7) == 0)
          in_gap = $urandom_range(1, 18);
      end
    end
    in_valid <= nxt_valid;
    in_item <= nxt_item;
  end

  // Receiver: stalls in random bursts, sometimes followed by a calm stretch.
  always @(negedge clk) begin : recv_proc
    logic nxt_ready;
    nxt_ready = 1'b1;
    if (stall_left > 0) begin
      stall_left--;
      nxt_ready = 1'b0;
      if (stall_left == 0 && $urandom_range(0, 3) == 0) calm_left = $urandom_range(40, 120);
    end else if (calm_left > 0) begin
      calm_left--;
    end else if (feed_idx + TAIL_ITEMS < stim_items.size() && $urandom_range(0, 15) == 0) begin
      stall_left = $urandom_range(1, 18) - 1;
      nxt_ready = 1'b0;
    end
    out_ready <= nxt_ready;
  end

  always @(posedge clk) begin : mon_proc
    out_item_t want;
    in_taken <= rst_n && in_valid && in_ready;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (due_verdicts.size() == 0) begin
          $display("%0t: unexpected report, expected none, got matched=%0b overflow=%0b",
                   $time, out_item.matched, out_item.overflow);
          errors++;
        end else begin
          want = due_verdicts.pop_front();
          if (out_item.matched !== want.matched) begin
            $display("%0t: matched mismatch, expected %0b, got %0b",
                     $time, want.matched, out_item.matched);
            errors++;
          end
          if (out_item.overflow !== want.overflow) begin
            $display("%0t: overflow mismatch, expected %0b, got %0b",
                     $time, want.overflow, out_item.overflow);
            errors++;
          end
        end
      end
      if (in_valid && in_ready) glob_step(in_item);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
        $display("simulation failed");
        $finish;
      end
    end
  end

endmodule
